### hw/rtl/hbc_pkg.sv
// ----------------------------------------------------------------------------
// hbc_pkg: shared constants and types for the binned histogram counter
// Sizes of the bin store, counter width, operation codes and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package hbc_pkg;

  localparam int MAX_BINS    = 64;
  localparam int EXTRA_BINS  = 2;
  localparam int SLOT_COUNT  = MAX_BINS + EXTRA_BINS;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int COUNT_WIDTH = 32;

  localparam int DATA_W      = 32;  // sample, base, result fields
  localparam int SIZE_W      = 16;  // bin_size register
  localparam int BINS_W      = 7;   // bins_in_use register
  localparam int INDEX_W     = 8;   // bin_index field
  localparam int REG_IDX_W   = 2;

  localparam int DIV_STEPS   = DATA_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    FUNC_TALLY = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE        = 2'd0,
    REG_BIN_SIZE    = 2'd1,
    REG_BINS_IN_USE = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  localparam logic [SLOT_W-1:0] SLOT_UNDER = '0;
  localparam logic [SLOT_W-1:0] SLOT_OVER  = SLOT_W'(MAX_BINS + 1);

endpackage

`default_nettype wire

### hw/rtl/binned_histogram_counter.sv
// ----------------------------------------------------------------------------
// binned_histogram_counter: histogram with underflow and overflow bins
// Tallies signed samples into regular bins, reads single bins, clears all.
// ----------------------------------------------------------------------------
// Usage
//   Command port: an item is taken at a clock edge with start high and busy
//   low; func selects tally, read, clear or no operation. Exactly one result
//   beat follows each item, shown for one cycle with done high. The receiver
//   cannot hold results off; it must take each beat as it comes.
//   Config port: wr_en, wr_index and wr_data write base, bin_size and
//   bins_in_use; write only while busy is low.
//   Sequence: a tally at or above the base runs 32 restoring-division
//   steps (one quotient bit per cycle through the dividend shift
//   register), then picks the bin, reads the count memory and writes the
//   incremented count back. A tally below the base goes straight to the
//   underflow bin's read and write-back, an in-range read reads the count
//   memory, and clear, no-op and out-of-range reads answer from idle. busy
//   falls with done, so the next item may start in the cycle done is shown.
//   Reset: rst clears the configuration to base 0, bin_size 1, 64 bins, and
//   marks every bin count and the total as zero at once.
// ----------------------------------------------------------------------------
`default_nettype none

module binned_histogram_counter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    func,
  input  wire logic signed [hbc_pkg::DATA_W-1:0]  sample,
  input  wire logic signed [hbc_pkg::INDEX_W-1:0] bin_index,
  input  wire logic                          wr_en,
  input  wire logic [hbc_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic [hbc_pkg::DATA_W-1:0]    wr_data,
  output logic                               done,
  output logic [hbc_pkg::DATA_W-1:0]         bin_count,
  output logic [hbc_pkg::DATA_W-1:0]         total_count
);

  import hbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_QSLOT,
    S_RD,
    S_WB
  } state_t;

  state_t                    state;
  func_t                     op;
  func_t                     func_in;

  logic signed [DATA_W-1:0]  base;
  logic [SIZE_W-1:0]         bin_size;
  logic [BINS_W-1:0]         bins_in_use;

  logic [SIZE_W-1:0]         size_eff;
  logic [BINS_W-1:0]         bins_eff;

  logic [SLOT_W-1:0]         slot;
  logic [DATA_W-1:0]         dq;
  logic [SIZE_W-1:0]         rem;
  logic [STEP_W-1:0]         step;

  logic [DATA_W:0]           diff;
  logic [SIZE_W+1:0]         trial;
  logic                      borrow;

  logic [COUNT_WIDTH-1:0]    total;
  logic [COUNT_WIDTH-1:0]    total_inc;
  logic [SLOT_COUNT-1:0]     valid;

  logic [COUNT_WIDTH-1:0]    mem [SLOT_COUNT];
  logic [COUNT_WIDTH-1:0]    mem_q;
  logic [COUNT_WIDTH-1:0]    cur_count;
  logic [COUNT_WIDTH-1:0]    wr_count;
  logic                      mem_we;

  logic                      q_over;
  logic                      idx_hit;
  logic [SLOT_W-1:0]         idx_slot;

  assign func_in  = func_t'(func);
  assign busy     = (state != S_IDLE);

  assign size_eff = (bin_size == '0) ? SIZE_W'(1) : bin_size;
  always_comb begin
    if (bins_in_use == '0) begin
      bins_eff = BINS_W'(1);
    end else if (int'(bins_in_use) > MAX_BINS) begin
      bins_eff = BINS_W'(MAX_BINS);
    end else begin
      bins_eff = bins_in_use;
    end
  end

  // full-precision difference; the top bit is the sign
  assign diff = {sample[DATA_W-1], sample} - {base[DATA_W-1], base};

  // one restoring-division step on the next dividend bit
  assign trial  = {1'b0, rem, dq[DATA_W-1]} - {2'b00, size_eff};
  assign borrow = trial[SIZE_W+1];

  // quotient at or beyond the bins in use selects the overflow bin
  assign q_over = (|dq[DATA_W-1:BINS_W]) || (dq[BINS_W-1:0] >= bins_eff);

  // read index decode: all ones is the underflow bin
  always_comb begin
    idx_hit  = 1'b0;
    idx_slot = SLOT_UNDER;
    if (bin_index[INDEX_W-1]) begin
      idx_hit  = (&bin_index);
      idx_slot = SLOT_UNDER;
    end else if (INDEX_W'(bin_index[INDEX_W-2:0]) == INDEX_W'(bins_eff)) begin
      idx_hit  = 1'b1;
      idx_slot = SLOT_OVER;
    end else if (INDEX_W'(bin_index[INDEX_W-2:0]) < INDEX_W'(bins_eff)) begin
      idx_hit  = 1'b1;
      idx_slot = SLOT_W'(bin_index[INDEX_W-2:0]) + SLOT_W'(1);
    end
  end

  assign cur_count = valid[slot] ? mem_q : '0;
  assign wr_count  = cur_count + COUNT_WIDTH'(1);
  assign total_inc = total + COUNT_WIDTH'(1);
  assign mem_we    = (state == S_WB) && (op == FUNC_TALLY);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot] <= wr_count;
    end
    mem_q <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base        <= '0;
      bin_size    <= SIZE_W'(1);
      bins_in_use <= BINS_W'(MAX_BINS);
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_BASE:        base        <= wr_data;
        REG_BIN_SIZE:    bin_size    <= wr_data[SIZE_W-1:0];
        REG_BINS_IN_USE: bins_in_use <= wr_data[BINS_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= FUNC_NOP;
      done        <= 1'b0;
      total       <= '0;
      valid       <= '0;
      step        <= '0;
      bin_count   <= '0;
      total_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= func_in;
            case (func_in)
              FUNC_TALLY: begin
                if (diff[DATA_W]) begin
                  slot  <= SLOT_UNDER;
                  state <= S_RD;
                end else begin
                  dq    <= diff[DATA_W-1:0];
                  rem   <= '0;
                  step  <= '0;
                  state <= S_DIV;
                end
              end
              FUNC_READ: begin
                if (idx_hit) begin
                  slot  <= idx_slot;
                  state <= S_RD;
                end else begin
                  done        <= 1'b1;
                  bin_count   <= '0;
                  total_count <= DATA_W'(total);
                end
              end
              FUNC_CLEAR: begin
                valid       <= '0;
                total       <= '0;
                done        <= 1'b1;
                bin_count   <= '0;
                total_count <= '0;
              end
              default: begin
                done        <= 1'b1;
                bin_count   <= '0;
                total_count <= DATA_W'(total);
              end
            endcase
          end
        end
        S_DIV: begin
          if (borrow) begin
            rem <= {rem[SIZE_W-2:0], dq[DATA_W-1]};
          end else begin
            rem <= trial[SIZE_W-1:0];
          end
          dq   <= {dq[DATA_W-2:0], ~borrow};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_QSLOT;
          end
        end
        S_QSLOT: begin
          slot  <= q_over ? SLOT_OVER : (SLOT_W'(dq[BINS_W-1:0]) + SLOT_W'(1));
          state <= S_RD;
        end
        S_RD: begin
          // memory read of the chosen slot lands next cycle
          state <= S_WB;
        end
        S_WB: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (op == FUNC_TALLY) begin
            valid[slot] <= 1'b1;
            total       <= total_inc;
            bin_count   <= '0;
            total_count <= DATA_W'(total_inc);
          end else begin
            bin_count   <= DATA_W'(cur_count);
            total_count <= DATA_W'(total);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
